// ===== hdl/cobsfr_pkg.sv =====
// Package for the COBS frame receiver: phase encoding, frame size limits
// and the structure that carries one decoded byte between modules.
// No dependencies.
`timescale 1ns / 1ps

package cobsfr_pkg;

   localparam int MAX_DATA = 64;
   localparam logic [7:0] FRAME_LIMIT = 8'(MAX_DATA + 4);
   localparam logic [6:0] LAST_INDEX = 7'(MAX_DATA + 3);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_FIRST = 2'd1,
      PH_FRAME = 2'd2
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] frame_byte;
      logic [6:0] byte_index;
      logic       frame_end;
      logic       frame_abort;
   } result_type;

endpackage

// ===== hdl/cobsfr_decode.sv =====
// Frame state and COBS decoding for the receiver: one raw byte in per step,
// at most one decoded byte out. Depends on cobsfr_pkg.
`timescale 1ns / 1ps

module cobsfr_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             rx_byte,
   output cobsfr_pkg::result_type result
);

   cobsfr_pkg::phase_type phase_ff, phase_in;
   logic [6:0] position_ff, position_in;
   logic [7:0] zero_countdown_ff, zero_countdown_in;
   logic [7:0] declared_length_ff, declared_length_in;

   logic [7:0] cnt_dec;
   logic       zero_hit;
   logic [7:0] byte_out;
   logic [7:0] length_now;
   logic [7:0] next_pos;
   logic       done;
   logic       over;

   always_comb begin
      cnt_dec    = zero_countdown_ff - 8'd1;
      zero_hit   = (cnt_dec == 8'd0);
      byte_out   = zero_hit ? 8'd0 : rx_byte;
      length_now = (position_ff == 7'd0) ? byte_out : declared_length_ff;
      next_pos   = {1'b0, position_ff} + 8'd1;
      done       = ({1'b0, next_pos} >= ({1'b0, length_now} + 9'd4));
      over       = !done && (next_pos >= cobsfr_pkg::FRAME_LIMIT);
   end

   always_comb begin
      phase_in           = phase_ff;
      position_in        = position_ff;
      zero_countdown_in  = zero_countdown_ff;
      declared_length_in = declared_length_ff;
      result             = '0;
      result.valid       = (rx_byte != 8'd0) && (phase_ff == cobsfr_pkg::PH_FRAME);
      result.frame_byte  = byte_out;
      result.byte_index  = position_ff;
      result.frame_end   = done;
      result.frame_abort = over;
      if (step_en) begin
         priority if (rx_byte == 8'd0) begin
            phase_in = cobsfr_pkg::PH_FIRST;
         end else if (phase_ff == cobsfr_pkg::PH_FIRST) begin
            zero_countdown_in = rx_byte;
            position_in       = 7'd0;
            phase_in          = cobsfr_pkg::PH_FRAME;
         end else if (phase_ff == cobsfr_pkg::PH_FRAME) begin
            zero_countdown_in  = zero_hit ? rx_byte : cnt_dec;
            declared_length_in = length_now;
            position_in        = next_pos[6:0];
            if (done || over) begin
               phase_in = cobsfr_pkg::PH_IDLE;
            end
         end else begin
            phase_in = phase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= cobsfr_pkg::PH_IDLE;
         position_ff        <= 7'd0;
         zero_countdown_ff  <= 8'd0;
         declared_length_ff <= 8'd0;
      end else begin
         phase_ff           <= phase_in;
         position_ff        <= position_in;
         zero_countdown_ff  <= zero_countdown_in;
         declared_length_ff <= declared_length_in;
      end
   end

   a_zero_resyncs: assert property (@(posedge clock) disable iff (reset)
      step_en && (rx_byte == 8'd0) |=> phase_ff == cobsfr_pkg::PH_FIRST)
      else $error("zero byte did not resynchronise the decoder");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> !(result.frame_end && result.frame_abort))
      else $error("frame end and abort raised together");

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == cobsfr_pkg::PH_FRAME |-> position_ff <= cobsfr_pkg::LAST_INDEX)
      else $error("frame position ran past the size limit");

   a_countdown_live: assert property (@(posedge clock) disable iff (reset)
      step_en && result.valid |=> zero_countdown_ff != 8'd0)
      else $error("countdown left at zero after a frame byte");

endmodule

// ===== hdl/cobs_frame_receiver_top.sv =====
// Top level of the COBS frame receiver: request and response registers
// around the decoder. Depends on cobsfr_pkg and cobsfr_decode.
`timescale 1ns / 1ps
//
// The request channel takes one raw serial byte per request on req_rx_byte.
// A zero byte always resynchronises the receiver; the byte after it is the
// first COBS countdown. Decoded bytes leave on the response channel with
// their frame position, and rsp_frame_end or rsp_frame_abort marks the last
// byte of a complete or an oversize frame. Zero bytes, the countdown byte
// after a zero and bytes received while not synchronised give no response.
// A request is captured in an input register and decoded into the response
// register by the decode step that follows, which can stall as described below.
// One request can be accepted in every cycle while responses are taken;
// this is set by the single decode step between the two registers.
// When the response is not taken, the pending request still advances if it
// produces no response; otherwise req_ready falls until rsp_ready returns.
// Reset empties both registers and returns the receiver to the idle state.

module cobs_frame_receiver_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_frame_byte,
   output logic [6:0] rsp_byte_index,
   output logic       rsp_frame_end,
   output logic       rsp_frame_abort
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   cobsfr_pkg::result_type out_ff;
   cobsfr_pkg::result_type result;
   logic       out_free;
   logic       step_en;

   cobsfr_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_comb begin
      out_free     = !out_valid_ff || rsp_ready;
      step_en      = in_valid_ff && (out_free || !result.valid);
      req_ready    = !in_valid_ff || step_en;
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      out_valid_in = (step_en && result.valid) || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step_en && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_frame_byte  = out_ff.frame_byte;
   assign rsp_byte_index  = out_ff.byte_index;
   assign rsp_frame_end   = out_ff.frame_end;
   assign rsp_frame_abort = out_ff.frame_abort;

   a_abort_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_abort |-> rsp_byte_index == cobsfr_pkg::LAST_INDEX)
      else $error("abort flagged away from the last allowed position");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      step_en && result.valid |-> out_free)
      else $error("decoded byte would overwrite a pending response");

   a_step_needs_data: assert property (@(posedge clock) disable iff (reset)
      step_en |-> in_valid_ff)
      else $error("decoder stepped without a pending request");

endmodule
